/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define PRR_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed: invariant");
// same-cycle implication
`define PRR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed: implication");
// next-cycle implication
`define PRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define PRR_ASSERT_ALWAYS(lbl, clk, rstn, cond)
`define PRR_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define PRR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* design/prr_pkg.sv */
// ----------------------------------------------------------------------------
// prr_pkg
// types, constants and codes shared by the polyphase resampler
// ----------------------------------------------------------------------------
package prr_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_WIDTH     = 16;
    localparam int COEF_IDX_W     = 14;
    localparam int FRAC_BITS      = 15;
    localparam int ROUND_BIAS     = 1 << (FRAC_BITS - 1);

    localparam int UP_W           = 9;
    localparam int DOWN_W         = 11;
    localparam int TAPS_W         = 15;
    localparam int MAX_UP         = 256;
    localparam int MAX_DOWN       = 1024;
    localparam int MAX_OUT        = 64;
    localparam int CNT_W          = 7;
    localparam int OFS_W          = 10;
    localparam int POS_W          = 11;
    localparam int BIT_W          = 4;

    localparam int COEF_DEPTH_DEF = 16384;
    localparam int HIST_DEPTH_DEF = 256;

    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_UP_FACTOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DOWN_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_TAPS    = 2'd2;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_COEF   = 1'b1;

    typedef struct packed {
        logic                           req_type;
        logic signed [SAMPLE_WIDTH-1:0] sample_in;
        logic [COEF_IDX_W-1:0]          coef_index;
        logic signed [COEF_WIDTH-1:0]   coef_value;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample_out;
        logic                           last_of_run;
        logic                           saturated;
    } out_item_t;

    typedef enum logic [2:0] {
        ALU_NOP,
        ALU_CLR,
        ALU_MAC,
        ALU_SCALE,
        ALU_ROUND
    } alu_op_t;

    typedef struct packed {
        alu_op_t op;
        logic    mul_en;
        logic    scale_bit;
    } mac_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MAC,
        ST_DRAIN,
        ST_SCALE,
        ST_ROUND,
        ST_EMIT
    } state_t;

endpackage

/* design/polyphase_rational_resampler.sv */
// ----------------------------------------------------------------------------
// polyphase_rational_resampler
// rational U/D resampler built on a polyphase FIR with one shared MAC unit
//
//   channel  | handshake               | payload
//   ---------+-------------------------+------------------------------
//   in       | in_valid / in_stall     | in_data  (prr_pkg::in_item_t)
//   out      | out_valid / out_stall   | out_data (prr_pkg::out_item_t)
//   cfg      | cfg_we                  | cfg_index, cfg_data
//
// for each result of a sample the sequencer walks T taps, where
// T = min(ceil((num_taps - phase) / U), history), through the coefficient
// memory read port, one per cycle
// no clearing pass after reset: the tap walk stops at the history fill count
// an output register holds the last result so the next item can be taken
// while it waits; a stalled output holds the sequencer in its emit step
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module polyphase_rational_resampler #(
    parameter int COEF_DEPTH = prr_pkg::COEF_DEPTH_DEF,
    parameter int HIST_DEPTH = prr_pkg::HIST_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  prr_pkg::in_item_t                  in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output prr_pkg::out_item_t                 out_data,
    input  logic                               cfg_we,
    input  logic [prr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [prr_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW  = prr_pkg::SAMPLE_WIDTH;
    localparam int CAW = $clog2(COEF_DEPTH);
    localparam int IW  = (CAW > prr_pkg::COEF_IDX_W) ? CAW : prr_pkg::COEF_IDX_W;
    localparam int NW  = ((CAW > prr_pkg::TAPS_W) ? CAW : prr_pkg::TAPS_W) + 1;
    localparam int HW  = $clog2(HIST_DEPTH);
    localparam int KW  = $clog2(HIST_DEPTH + 1);
    localparam int RW  = 2 * SW + KW + prr_pkg::UP_W;
    localparam int YW  = RW - prr_pkg::FRAC_BITS;
    localparam int UW  = prr_pkg::UP_W;
    localparam int DW  = prr_pkg::DOWN_W;
    localparam int PSW = prr_pkg::POS_W;
    localparam int CW  = prr_pkg::CNT_W;
    localparam logic signed [YW-1:0] Y_HI = YW'((1 << (SW - 1)) - 1);
    localparam logic signed [YW-1:0] Y_LO = ~Y_HI;

    // configuration
    logic [UW-1:0]                 up_factor_reg;
    logic [DW-1:0]                 down_factor_reg;
    logic [prr_pkg::TAPS_W-1:0]    num_taps_reg;

    // sequencer
    prr_pkg::state_t               state_reg, state_next;
    logic [UW-1:0]                 u_reg, u_next;
    logic [DW-1:0]                 d_reg, d_next;
    logic [NW-1:0]                 taps_reg, taps_next;
    logic [PSW-1:0]                o_reg, o_next;
    logic [prr_pkg::OFS_W-1:0]     next_off_reg, next_off_next;
    logic [CW-1:0]                 cnt_reg, cnt_next;
    logic [NW-1:0]                 n_reg, n_next;
    logic [KW-1:0]                 k_reg, k_next;
    logic [HW-1:0]                 ridx_reg, ridx_next;
    logic [HW-1:0]                 cur_reg, cur_next;
    logic [prr_pkg::BIT_W-1:0]     bit_reg, bit_next;
    logic                          v1_reg, v1_next;
    logic                          v2_reg, v2_next;
    prr_pkg::out_item_t            out_reg, out_next;
    logic                          out_valid_reg, out_valid_next;

    // decoded
    logic                          in_xfer;
    logic                          is_sample, is_coef;
    logic                          o_lt_u, cnt_room, tap_go, out_free, last;
    logic [UW-1:0]                 u_clamp;
    logic [DW-1:0]                 d_clamp;
    logic [NW-1:0]                 taps_clamp;
    logic [IW-1:0]                 coef_wa;
    logic                          coef_we, ring_we, issue;
    prr_pkg::mac_ctl_t             mac_ctl;
    logic signed [RW-1:0]          mac_res;
    logic signed [YW-1:0]          y;
    logic                          sat_hi, sat_lo;
    logic signed [prr_pkg::COEF_WIDTH-1:0] coef_rd;
    logic signed [SW-1:0]          hist_rd;
    logic [HW-1:0]                 ring_ptr;
    logic [KW-1:0]                 ring_fill;

    assign in_xfer   = in_valid && !in_stall;
    assign is_sample = in_xfer && (in_data.req_type == prr_pkg::REQ_SAMPLE);
    assign is_coef   = in_xfer && (in_data.req_type == prr_pkg::REQ_COEF);
    assign coef_wa   = IW'(in_data.coef_index);

    assign u_clamp = (up_factor_reg == '0) ? UW'(1) :
                     ((32'(up_factor_reg) > prr_pkg::MAX_UP) ? UW'(prr_pkg::MAX_UP)
                                                             : up_factor_reg);
    assign d_clamp = (down_factor_reg == '0) ? DW'(1) :
                     ((32'(down_factor_reg) > prr_pkg::MAX_DOWN) ? DW'(prr_pkg::MAX_DOWN)
                                                                 : down_factor_reg);
    assign taps_clamp = (num_taps_reg == '0) ? NW'(1) :
                        ((32'(num_taps_reg) > COEF_DEPTH) ? NW'(COEF_DEPTH)
                                                          : NW'(num_taps_reg));

    assign o_lt_u   = o_reg < PSW'(u_reg);
    assign cnt_room = cnt_reg < CW'(prr_pkg::MAX_OUT);
    assign tap_go   = (n_reg < taps_reg) && (k_reg < ring_fill);
    assign out_free = !out_valid_reg || !out_stall;
    assign last     = ((o_reg + PSW'(d_reg)) >= PSW'(u_reg))
                      || (cnt_reg == CW'(prr_pkg::MAX_OUT - 1));

    // result after rounding is floor of (acc * U + half) / 2^15
    assign y      = mac_res[RW-1:prr_pkg::FRAC_BITS];
    assign sat_hi = y > Y_HI;
    assign sat_lo = y < Y_LO;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_factor_reg   <= UW'(1);
            down_factor_reg <= DW'(1);
            num_taps_reg    <= prr_pkg::TAPS_W'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                prr_pkg::CFG_UP_FACTOR:   up_factor_reg   <= cfg_data[UW-1:0];
                prr_pkg::CFG_DOWN_FACTOR: down_factor_reg <= cfg_data[DW-1:0];
                prr_pkg::CFG_NUM_TAPS:    num_taps_reg    <= cfg_data;
                default:                  num_taps_reg    <= num_taps_reg;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (is_sample)
                begin
                    state_next = prr_pkg::ST_CHECK;
                end
            end
            prr_pkg::ST_CHECK:
            begin
                if (!o_lt_u)
                begin
                    state_next = prr_pkg::ST_IDLE;
                end
                else if (cnt_room)
                begin
                    state_next = prr_pkg::ST_MAC;
                end
            end
            prr_pkg::ST_MAC:
            begin
                if (!tap_go)
                begin
                    state_next = prr_pkg::ST_DRAIN;
                end
            end
            prr_pkg::ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg)
                begin
                    state_next = prr_pkg::ST_SCALE;
                end
            end
            prr_pkg::ST_SCALE:
            begin
                if (bit_reg == '0)
                begin
                    state_next = prr_pkg::ST_ROUND;
                end
            end
            prr_pkg::ST_ROUND:
            begin
                state_next = prr_pkg::ST_EMIT;
            end
            prr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = prr_pkg::ST_CHECK;
                end
            end
            default:
            begin
                state_next = prr_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall          = (state_reg != prr_pkg::ST_IDLE);
        coef_we           = is_coef && (32'(in_data.coef_index) < COEF_DEPTH);
        ring_we           = is_sample;
        issue             = (state_reg == prr_pkg::ST_MAC) && tap_go;
        mac_ctl.op        = prr_pkg::ALU_NOP;
        mac_ctl.mul_en    = v1_reg;
        mac_ctl.scale_bit = u_reg[bit_reg];
        case (state_reg)
            prr_pkg::ST_CHECK:
            begin
                if (o_lt_u && cnt_room)
                begin
                    mac_ctl.op = prr_pkg::ALU_CLR;
                end
            end
            prr_pkg::ST_SCALE:
            begin
                mac_ctl.op = prr_pkg::ALU_SCALE;
            end
            prr_pkg::ST_ROUND:
            begin
                mac_ctl.op = prr_pkg::ALU_ROUND;
            end
            default:
            begin
                if (v2_reg)
                begin
                    mac_ctl.op = prr_pkg::ALU_MAC;
                end
            end
        endcase
    end

    // datapath registers
    always_comb
    begin
        u_next         = u_reg;
        d_next         = d_reg;
        taps_next      = taps_reg;
        o_next         = o_reg;
        next_off_next  = next_off_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        ridx_next      = ridx_reg;
        cur_next       = cur_reg;
        bit_next       = bit_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        v1_next        = issue;
        v2_next        = v1_reg;
        case (state_reg)
            prr_pkg::ST_IDLE:
            begin
                if (is_sample)
                begin
                    u_next    = u_clamp;
                    d_next    = d_clamp;
                    taps_next = taps_clamp;
                    o_next    = PSW'(next_off_reg);
                    cnt_next  = '0;
                    cur_next  = ring_ptr;
                end
            end
            prr_pkg::ST_CHECK:
            begin
                if (!o_lt_u)
                begin
                    next_off_next = prr_pkg::OFS_W'(o_reg - PSW'(u_reg));
                end
                else if (cnt_room)
                begin
                    n_next    = NW'(o_reg);
                    k_next    = '0;
                    ridx_next = cur_reg;
                end
                else
                begin
                    // result budget spent: the grid still advances
                    o_next = o_reg + PSW'(d_reg);
                end
            end
            prr_pkg::ST_MAC:
            begin
                if (tap_go)
                begin
                    n_next    = n_reg + NW'(u_reg);
                    k_next    = k_reg + 1'b1;
                    ridx_next = (ridx_reg == '0) ? HW'(HIST_DEPTH - 1) : ridx_reg - 1'b1;
                end
            end
            prr_pkg::ST_DRAIN:
            begin
                bit_next = prr_pkg::BIT_W'(UW - 1);
            end
            prr_pkg::ST_SCALE:
            begin
                bit_next = bit_reg - 1'b1;
            end
            prr_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.last_of_run = last;
                    out_next.saturated   = sat_hi || sat_lo;
                    if (sat_hi)
                    begin
                        out_next.sample_out = Y_HI[SW-1:0];
                    end
                    else if (sat_lo)
                    begin
                        out_next.sample_out = Y_LO[SW-1:0];
                    end
                    else
                    begin
                        out_next.sample_out = y[SW-1:0];
                    end
                    out_valid_next = 1'b1;
                    o_next         = o_reg + PSW'(d_reg);
                    cnt_next       = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                bit_next = bit_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prr_pkg::ST_IDLE;
            next_off_reg  <= '0;
            cnt_reg       <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            next_off_reg  <= next_off_next;
            cnt_reg       <= cnt_next;
            v1_reg        <= v1_next;
            v2_reg        <= v2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        u_reg    <= u_next;
        d_reg    <= d_next;
        taps_reg <= taps_next;
        o_reg    <= o_next;
        n_reg    <= n_next;
        k_reg    <= k_next;
        ridx_reg <= ridx_next;
        cur_reg  <= cur_next;
        bit_reg  <= bit_next;
        out_reg  <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    prr_coef_store #(
        .COEF_DEPTH (COEF_DEPTH)
    ) u_coef_store (
        .clk     (clk),
        .wr_en   (coef_we),
        .wr_addr (coef_wa[CAW-1:0]),
        .wr_data (in_data.coef_value),
        .rd_addr (n_reg[CAW-1:0]),
        .rd_data (coef_rd)
    );

    prr_hist_ring #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_hist_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (ring_we),
        .wr_data (in_data.sample_in),
        .rd_addr (ridx_reg),
        .rd_data (hist_rd),
        .wr_ptr  (ring_ptr),
        .fill    (ring_fill)
    );

    prr_mac_unit #(
        .HIST_DEPTH (HIST_DEPTH)
    ) u_mac_unit (
        .clk    (clk),
        .ctl    (mac_ctl),
        .coef   (coef_rd),
        .sample (hist_rd),
        .result (mac_res)
    );

    `PRR_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_reg <= CW'(prr_pkg::MAX_OUT))
    `PRR_ASSERT_IMPLY(a_scale_drained, clk, rst_n, state_reg == prr_pkg::ST_SCALE, !v1_reg && !v2_reg)
    `PRR_ASSERT_NEXT(a_emit_waits, clk, rst_n, state_reg == prr_pkg::ST_EMIT && out_valid_reg && out_stall, state_reg == prr_pkg::ST_EMIT)
    `PRR_ASSERT_IMPLY(a_tap_in_hist, clk, rst_n, state_reg == prr_pkg::ST_MAC, k_reg <= ring_fill)

endmodule

/* design/prr_coef_store.sv */
// ----------------------------------------------------------------------------
// prr_coef_store
// single-port-write, single-port-read coefficient memory, registered read
// ----------------------------------------------------------------------------
module prr_coef_store #(
    parameter int COEF_DEPTH = prr_pkg::COEF_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [$clog2(COEF_DEPTH)-1:0]           wr_addr,
    input  logic signed [prr_pkg::COEF_WIDTH-1:0]   wr_data,
    input  logic [$clog2(COEF_DEPTH)-1:0]           rd_addr,
    output logic signed [prr_pkg::COEF_WIDTH-1:0]   rd_data
);

    logic signed [prr_pkg::COEF_WIDTH-1:0] mem [COEF_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* design/prr_hist_ring.sv */
// ----------------------------------------------------------------------------
// prr_hist_ring
// sample history ring with write pointer and fill count
// ----------------------------------------------------------------------------
module prr_hist_ring #(
    parameter int HIST_DEPTH = prr_pkg::HIST_DEPTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    wr_en,
    input  logic signed [prr_pkg::SAMPLE_WIDTH-1:0] wr_data,
    input  logic [$clog2(HIST_DEPTH)-1:0]           rd_addr,
    output logic signed [prr_pkg::SAMPLE_WIDTH-1:0] rd_data,
    output logic [$clog2(HIST_DEPTH)-1:0]           wr_ptr,
    output logic [$clog2(HIST_DEPTH+1)-1:0]         fill
);

    localparam int HW = $clog2(HIST_DEPTH);
    localparam int KW = $clog2(HIST_DEPTH + 1);

    logic signed [prr_pkg::SAMPLE_WIDTH-1:0] mem [HIST_DEPTH];
    logic [HW-1:0] ptr_reg, ptr_next;
    logic [KW-1:0] fill_reg, fill_next;

    // entries at or beyond the fill count were never written; reads of them are not zeroed
    always_comb
    begin
        ptr_next  = ptr_reg;
        fill_next = fill_reg;
        if (wr_en)
        begin
            ptr_next = (ptr_reg == HW'(HIST_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;
            if (fill_reg != KW'(HIST_DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ptr_reg] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    assign wr_ptr = ptr_reg;
    assign fill   = fill_reg;

endmodule

/* design/prr_mac_unit.sv */
// ----------------------------------------------------------------------------
// prr_mac_unit
// registered multiplier plus one shared adder for accumulate, gain and rounding
// ----------------------------------------------------------------------------
module prr_mac_unit #(
    parameter int HIST_DEPTH = prr_pkg::HIST_DEPTH_DEF
) (
    input  logic                                    clk,
    input  prr_pkg::mac_ctl_t                       ctl,
    input  logic signed [prr_pkg::COEF_WIDTH-1:0]   coef,
    input  logic signed [prr_pkg::SAMPLE_WIDTH-1:0] sample,
    output logic signed [2*prr_pkg::SAMPLE_WIDTH + $clog2(HIST_DEPTH+1)
                         + prr_pkg::UP_W - 1:0]     result
);

    localparam int PW = prr_pkg::COEF_WIDTH + prr_pkg::SAMPLE_WIDTH;
    localparam int AW = 2 * prr_pkg::SAMPLE_WIDTH + $clog2(HIST_DEPTH + 1);
    localparam int RW = AW + prr_pkg::UP_W;

    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] r_reg, r_next;
    logic signed [RW-1:0] op_a, op_b, sum;

    // one adder serves all three uses
    always_comb
    begin
        op_a     = '0;
        op_b     = '0;
        acc_next = acc_reg;
        r_next   = r_reg;
        case (ctl.op)
            prr_pkg::ALU_CLR:
            begin
                acc_next = '0;
                r_next   = '0;
            end
            prr_pkg::ALU_MAC:
            begin
                op_a = {{(RW-AW){acc_reg[AW-1]}}, acc_reg};
                op_b = {{(RW-PW){prod_reg[PW-1]}}, prod_reg};
            end
            prr_pkg::ALU_SCALE:
            begin
                // msb-first shift-and-add multiply by the gain
                op_a = {r_reg[RW-2:0], 1'b0};
                if (ctl.scale_bit)
                begin
                    op_b = {{(RW-AW){acc_reg[AW-1]}}, acc_reg};
                end
            end
            prr_pkg::ALU_ROUND:
            begin
                op_a = r_reg;
                op_b = RW'(prr_pkg::ROUND_BIAS);
            end
            default:
            begin
                op_a = '0;
            end
        endcase
        sum = op_a + op_b;
        case (ctl.op)
            prr_pkg::ALU_MAC:   acc_next = sum[AW-1:0];
            prr_pkg::ALU_SCALE: r_next   = sum;
            prr_pkg::ALU_ROUND: r_next   = sum;
            default:            r_next   = r_next;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctl.mul_en)
        begin
            prod_reg <= coef * sample;
        end
        acc_reg <= acc_next;
        r_reg   <= r_next;
    end

    assign result = r_reg;

endmodule
